### sv/tws_pkg.sv
`timescale 1ns / 1ps

package tws_pkg;

   // What an accepted sample turns into at the output stage.
   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_SMOOTH,
      KIND_REPEAT,
      KIND_ERROR,
      KIND_PASS
   } item_kind_type;

   localparam int CSR_ADDR_BITS   = 3;
   localparam int CSR_DATA_BITS   = 32;
   localparam int HALF_WIDTH_BITS = 5;
   localparam int RECIP_BITS      = 24;
   localparam int RECIP_LO_BITS   = 12;
   localparam int RECIP_HI_BITS   = RECIP_BITS - RECIP_LO_BITS;
   localparam int ROUND_HALF      = 1 << (RECIP_BITS - 1);

   // Register index, taken from csr_paddr[2].
   localparam logic CSR_HALF_WIDTH = 1'b0;
   localparam logic CSR_RECIP      = 1'b1;

endpackage

### sv/triangular_window_smoother.sv
`timescale 1ns / 1ps

// Triangular window smoother.
// Samples arrive on the req_ channel (req_sample, req_last_in marks the end of a
// vector) and results leave on the rsp_ channel; a transfer happens at a clock
// edge with valid high and stall low. half_width and recip_scale are written over
// the csr_ port at byte addresses 0 and 4; the user must do so only while the
// block is idle, which the block itself does not enforce. An item passes through
// four register stages (tap products and group sums, final sum, normalizing
// multiply, round and saturate) into the output register.
// One sample is taken every cycle while req_stall is low. A sample that yields
// h+1 results (the first smoothed value, or the tail of a vector) holds the
// output register until all of them have transferred, and stalls the input
// once the stages behind it are full; the output counter o_rem counts them down.
// Samples that yield no result never enter the pipeline.
// While rsp_stall is high the output register holds its result; the stages
// behind it keep filling empty slots and stall the input only once full.
// Reset clears the window, the sample count, both registers, the held
// smoothed value and every valid bit.

module triangular_window_smoother
   import tws_pkg::*;
#(
   parameter int MAX_HALF    = 16,
   parameter int SAMPLE_BITS = 24,
   parameter int MAX_LEN     = 65535
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_last_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_smoothed,
   output logic                          rsp_last_out,
   output logic                          rsp_too_short,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]      csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]      csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]      csr_prdata,
   output logic                          csr_pready
);

   localparam int TAPS   = 2 * MAX_HALF + 1;
   localparam int HB     = $clog2(MAX_HALF + 1);
   localparam int CB     = $clog2(MAX_LEN + 1);
   localparam int PRODB  = SAMPLE_BITS + HB + 1;
   localparam int GROUPS = (TAPS + 3) / 4;
   localparam int PB     = PRODB + 2;
   localparam int AB     = SAMPLE_BITS + $clog2(MAX_HALF * (MAX_HALF + 2) + 1) + 1;
   localparam int AW     = AB + RECIP_HI_BITS;
   localparam int BW     = AB + RECIP_LO_BITS + 1;
   localparam int QW     = AB + RECIP_BITS + 2;

   typedef struct packed {
      item_kind_type          kind;
      logic [HB-1:0]          rem;
      logic                   last;
      logic [SAMPLE_BITS-1:0] val;
   } desc_type;

   // Configuration.
   logic [HALF_WIDTH_BITS-1:0] half_width_ff, half_width_in;
   logic [RECIP_BITS-1:0]      recip_scale_ff, recip_scale_in;
   logic                       csr_write;

   // Front end and stage 1.
   logic [SAMPLE_BITS-1:0] window_ff [TAPS];
   logic [SAMPLE_BITS-1:0] window_in [TAPS];
   logic [CB-1:0]          sample_count_ff, sample_count_in;
   logic [HB-1:0]          h_now;
   desc_type               desc_now;
   logic                   accept;
   logic                   s1_v_ff, s1_v_in;
   desc_type               s1_d_ff;
   logic [HB-1:0]          s1_h_ff;

   // Stage 2.
   logic signed [PRODB-1:0] prod [TAPS];
   logic signed [PB-1:0]    s2_part_in [GROUPS];
   logic signed [PB-1:0]    s2_part_ff [GROUPS];
   logic                    s2_v_ff;
   desc_type                s2_d_ff;

   // Stage 3.
   logic signed [AB-1:0] acc_in, acc_ff;
   logic                 s3_v_ff;
   desc_type             s3_d_ff;

   // Stage 4.
   logic [AB-1:0] mag;
   logic [AW-1:0] a_in, a_ff;
   logic [BW-1:0] b_in, b_ff;
   logic          neg_ff;
   logic          s4_v_ff;
   desc_type      s4_d_ff;

   // Output stage.
   logic [QW-1:0]          q_sum, q_val;
   logic [SAMPLE_BITS-1:0] smooth_val;
   logic [SAMPLE_BITS-1:0] last_smoothed_ff, last_smoothed_in;
   logic                   o_valid_ff, o_valid_in;
   logic [SAMPLE_BITS-1:0] o_data_ff, o_data_in;
   logic                   o_last_ff, o_last_in;
   logic                   o_err_ff, o_err_in;
   logic [HB-1:0]          o_rem_ff, o_rem_in;
   logic                   o_rep_ff, o_rep_in;

   logic o_ready, s4_ready, s3_ready, s2_ready, s1_ready;

   // Each stage moves when it is empty or the stage after it moves.
   assign o_ready  = !o_valid_ff || (!rsp_stall && (o_rem_ff == '0));
   assign s4_ready = !s4_v_ff || o_ready;
   assign s3_ready = !s3_v_ff || s4_ready;
   assign s2_ready = !s2_v_ff || s3_ready;
   assign s1_ready = !s1_v_ff || s2_ready;

   assign req_stall = !s1_ready;
   assign accept    = req_valid && s1_ready;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      half_width_in  = half_width_ff;
      recip_scale_in = recip_scale_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            CSR_HALF_WIDTH: half_width_in  = csr_pwdata[HALF_WIDTH_BITS-1:0];
            CSR_RECIP:      recip_scale_in = csr_pwdata[RECIP_BITS-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         CSR_HALF_WIDTH: csr_prdata = CSR_DATA_BITS'(half_width_ff);
         CSR_RECIP:      csr_prdata = CSR_DATA_BITS'(recip_scale_ff);
      endcase
   end

   // ---------------- front end: classify the sample ----------------
   always_comb begin
      int iv;
      int hv;
      iv = int'(sample_count_ff);
      if (int'(half_width_ff) > MAX_HALF) begin
         h_now = HB'(MAX_HALF);
      end else begin
         h_now = HB'(half_width_ff);
      end
      hv = int'(h_now);

      desc_now.kind = KIND_NONE;
      desc_now.rem  = '0;
      desc_now.last = req_last_in;
      desc_now.val  = req_sample;
      if (hv == 0) begin
         desc_now.kind = KIND_PASS;
      end else if (req_last_in) begin
         if (iv < 2 * hv + 1) begin
            desc_now.kind = KIND_ERROR;
         end else begin
            desc_now.kind = KIND_REPEAT;
            desc_now.rem  = h_now;
         end
      end else if (iv >= 2 * hv) begin
         desc_now.kind = KIND_SMOOTH;
         // The first smoothed value also stands in for the h head outputs.
         if (iv == 2 * hv) begin
            desc_now.rem = h_now;
         end
      end

      sample_count_in = sample_count_ff;
      if (accept) begin
         if (req_last_in) begin
            sample_count_in = '0;
         end else if (sample_count_ff != CB'(MAX_LEN)) begin
            sample_count_in = sample_count_ff + 1'b1;
         end
      end

      s1_v_in = accept && (desc_now.kind != KIND_NONE);

      window_in[0] = req_sample;
      for (int k = 1; k < TAPS; k++) begin
         window_in[k] = window_ff[k-1];
      end
   end

   // ---------------- stage 1 -> 2: tap products and group sums ----------------
   always_comb begin
      int hv;
      int wv;
      logic [HB-1:0] w;
      logic signed [PB-1:0] part;
      hv = int'(s1_h_ff);
      for (int k = 0; k < TAPS; k++) begin
         if (k < hv) begin
            wv = k + 1;
         end else if (k == hv) begin
            wv = hv;
         end else if (k <= 2 * hv) begin
            wv = 2 * hv + 1 - k;
         end else begin
            wv = 0;
         end
         w = HB'(wv);
         prod[k] = $signed({1'b0, w}) * $signed(window_ff[k]);
      end
      for (int g = 0; g < GROUPS; g++) begin
         part = '0;
         for (int j = 0; j < 4; j++) begin
            if (4 * g + j < TAPS) begin
               part = part + PB'(prod[4 * g + j]);
            end
         end
         s2_part_in[g] = part;
      end
   end

   // ---------------- stage 2 -> 3: final sum ----------------
   always_comb begin
      acc_in = '0;
      for (int g = 0; g < GROUPS; g++) begin
         acc_in = acc_in + AB'(s2_part_ff[g]);
      end
   end

   // ---------------- stage 3 -> 4: magnitude times Q24 reciprocal ----------------
   // The reciprocal is split in two halves so each product stays narrow.
   always_comb begin
      mag  = acc_ff[AB-1] ? AB'(-acc_ff) : AB'(acc_ff);
      a_in = AW'(mag) * AW'(recip_scale_ff[RECIP_BITS-1:RECIP_LO_BITS]);
      b_in = BW'(mag) * BW'(recip_scale_ff[RECIP_LO_BITS-1:0]) + BW'(ROUND_HALF);
   end

   // ---------------- stage 4 -> output: round, saturate, repeat ----------------
   always_comb begin
      q_sum = QW'(a_ff) + QW'(b_ff >> RECIP_LO_BITS);
      q_val = q_sum >> RECIP_LO_BITS;
      if (neg_ff) begin
         if (q_val > QW'(64'd1 << (SAMPLE_BITS - 1))) begin
            smooth_val = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
         end else begin
            smooth_val = -SAMPLE_BITS'(q_val);
         end
      end else begin
         if (q_val > QW'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1)) begin
            smooth_val = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
         end else begin
            smooth_val = SAMPLE_BITS'(q_val);
         end
      end

      o_valid_in       = o_valid_ff;
      o_data_in        = o_data_ff;
      o_last_in        = o_last_ff;
      o_err_in         = o_err_ff;
      o_rem_in         = o_rem_ff;
      o_rep_in         = o_rep_ff;
      last_smoothed_in = last_smoothed_ff;

      if (o_ready) begin
         o_valid_in = s4_v_ff;
         o_rem_in   = '0;
         o_rep_in   = 1'b0;
         o_err_in   = 1'b0;
         o_last_in  = 1'b0;
         if (s4_v_ff) begin
            case (s4_d_ff.kind)
               KIND_SMOOTH: begin
                  o_data_in        = smooth_val;
                  o_rem_in         = s4_d_ff.rem;
                  last_smoothed_in = smooth_val;
               end
               KIND_REPEAT: begin
                  // Earlier smoothed items have already passed this stage.
                  o_data_in = last_smoothed_ff;
                  o_rem_in  = s4_d_ff.rem;
                  o_rep_in  = 1'b1;
                  o_last_in = (s4_d_ff.rem == '0);
               end
               KIND_ERROR: begin
                  o_data_in = '0;
                  o_last_in = 1'b1;
                  o_err_in  = 1'b1;
               end
               KIND_PASS: begin
                  o_data_in = s4_d_ff.val;
                  o_last_in = s4_d_ff.last;
               end
               default: begin
                  o_valid_in = 1'b0;
               end
            endcase
         end
      end else if (o_valid_ff && !rsp_stall) begin
         // Another copy of the same value follows this transfer.
         o_rem_in  = o_rem_ff - 1'b1;
         o_last_in = o_rep_ff && (o_rem_ff == HB'(1));
      end
   end

   assign rsp_valid     = o_valid_ff;
   assign rsp_smoothed  = o_data_ff;
   assign rsp_last_out  = o_last_ff;
   assign rsp_too_short = o_err_ff;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         half_width_ff    <= '0;
         recip_scale_ff   <= '0;
         sample_count_ff  <= '0;
         last_smoothed_ff <= '0;
         s1_v_ff          <= 1'b0;
         s2_v_ff          <= 1'b0;
         s3_v_ff          <= 1'b0;
         s4_v_ff          <= 1'b0;
         o_valid_ff       <= 1'b0;
         o_rem_ff         <= '0;
         o_rep_ff         <= 1'b0;
         for (int k = 0; k < TAPS; k++) begin
            window_ff[k] <= '0;
         end
      end else begin
         half_width_ff    <= half_width_in;
         recip_scale_ff   <= recip_scale_in;
         sample_count_ff  <= sample_count_in;
         last_smoothed_ff <= last_smoothed_in;
         o_valid_ff       <= o_valid_in;
         o_rem_ff         <= o_rem_in;
         o_rep_ff         <= o_rep_in;
         if (accept) begin
            window_ff <= window_in;
         end
         if (s1_ready) begin
            s1_v_ff <= s1_v_in;
         end
         if (s2_ready) begin
            s2_v_ff <= s1_v_ff;
         end
         if (s3_ready) begin
            s3_v_ff <= s2_v_ff;
         end
         if (s4_ready) begin
            s4_v_ff <= s3_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      o_data_ff <= o_data_in;
      o_last_ff <= o_last_in;
      o_err_ff  <= o_err_in;
      if (s1_ready) begin
         s1_d_ff <= desc_now;
         s1_h_ff <= h_now;
      end
      if (s2_ready) begin
         s2_d_ff    <= s1_d_ff;
         s2_part_ff <= s2_part_in;
      end
      if (s3_ready) begin
         s3_d_ff <= s2_d_ff;
         acc_ff  <= acc_in;
      end
      if (s4_ready) begin
         s4_d_ff <= s3_d_ff;
         a_ff    <= a_in;
         b_ff    <= b_in;
         neg_ff  <= acc_ff[AB-1];
      end
   end

endmodule

### sv/tws_checker.sv
`timescale 1ns / 1ps

module tws_checker #(
   parameter int SAMPLE_BITS = 24
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [SAMPLE_BITS-1:0] rsp_smoothed,
   input logic                          rsp_last_out,
   input logic                          rsp_too_short
);

   // A stalled result holds all of its fields.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_smoothed)
         && $stable(rsp_last_out) && $stable(rsp_too_short))
      else $error("stalled result changed");

   // A short vector ends in a single zero result that closes the vector.
   a_short_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_too_short |-> rsp_last_out && (rsp_smoothed == '0))
      else $error("malformed short-vector result");

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind triangular_window_smoother tws_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_tws_checker (.*);
